[design/efsd_pkg.sv]
package efsd_pkg;

    // configuration register indexes (byte address bit 2)
    localparam logic RegActive = 1'b0;
    localparam logic RegLimit  = 1'b1;

    // reset values of the configuration registers
    localparam logic [4:0]  ActiveReset = 5'd1;
    localparam logic [15:0] LimitReset  = 16'd20;

    // saturation value for times and counts
    localparam logic [31:0] TimeMax = 32'hFFFF_FFFF;

    // sequencer states
    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_SCAN  = 5'b00010,
        S_START = 5'b00100,
        S_SUM   = 5'b01000,
        S_DONE  = 5'b10000
    } t_state;

    // configuration as seen by the datapath
    typedef struct packed {
        logic [4:0]  active_servers;
        logic [15:0] wait_limit;
    } t_cfg;

endpackage

[design/efsd_cfg.sv]
module efsd_cfg (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    output efsd_pkg::t_cfg      o_cfg
);

    logic [4:0]  r_active;
    logic [15:0] r_limit;
    logic        wr_en;

    assign wr_en  = psel & penable & pwrite;
    assign pready = 1'b1;

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= efsd_pkg::ActiveReset;
            r_limit  <= efsd_pkg::LimitReset;
        end else if (wr_en) begin
            unique case (paddr[2])
                efsd_pkg::RegActive: r_active <= pwdata[4:0];
                efsd_pkg::RegLimit:  r_limit  <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    // read mux
    always_comb begin
        unique case (paddr[2])
            efsd_pkg::RegActive: prdata = {27'd0, r_active};
            efsd_pkg::RegLimit:  prdata = {16'd0, r_limit};
            default:             prdata = 32'd0;
        endcase
    end

    assign o_cfg.active_servers = r_active;
    assign o_cfg.wait_limit     = r_limit;

endmodule

[design/efsd_mem.sv]
module efsd_mem #(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_rd_en,
    input  logic [AW-1:0] i_rd_addr,
    output logic [31:0]   o_rd_data,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  logic [31:0]   i_wr_data
);

    logic [31:0]      mem [DEPTH];
    logic [DEPTH-1:0] r_valid;
    logic [31:0]      r_rd_data;
    logic             r_rd_valid;

    // free-time storage, written once per item
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= mem[i_rd_addr];
        end
    end

    // valid bits: an entry never written reads as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_valid[i_wr_addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_valid <= r_valid[i_rd_addr] & ~(i_wr_en & (i_wr_addr == i_rd_addr));
            end
        end
    end

    assign o_rd_data = r_rd_valid ? r_rd_data : 32'd0;

endmodule

[design/earliest_free_server_dispatch.sv]
// Earliest-free-server dispatcher.
// Input channel: i_valid / o_stall carry one job (arrival time, service time).
// Output channel: o_valid / i_stall carry one result per job: chosen server,
// start time, wait, over-limit flag and the running over-limit count.
// An item is taken at a clock edge with valid high and stall low.
// Each job scans the active servers' free times one per cycle through a single
// comparator reading a memory with one read and one write port, then steps
// through start, end/wait and the limit check, reusing the same comparator.
// The servers scanned are those in use (1 to MAX_SERVERS); a new job is
// taken only after the last job's result has gone to the output register.
// o_stall is high from accept until the result is moved to the output
// register; a result still waiting on the output does not block the next
// accept, but the following result holds until the output register is free.
// Synchronous reset (i_rst_n low) makes all free times read as zero, clears the
// over-limit count to zero, and loads active_servers = 1, wait_limit = 20.
// Configuration: APB-style port, active_servers at 0x0, wait_limit at 0x4.
module earliest_free_server_dispatch #(
    parameter int MAX_SERVERS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [31:0] i_arrival_time,
    input  logic [15:0] i_service_time,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [3:0]  o_server_index,
    output logic [31:0] o_start_time,
    output logic [31:0] o_wait_time,
    output logic        o_over_limit,
    output logic [31:0] o_over_total,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int AW = (MAX_SERVERS > 1) ? $clog2(MAX_SERVERS) : 1;
    localparam logic [8:0] MaxUsed = 9'(MAX_SERVERS);

    efsd_pkg::t_cfg   cfg;
    efsd_pkg::t_state r_state, n_state;

    logic [31:0]   r_arrival;
    logic [15:0]   r_service;
    logic [AW-1:0] r_last;
    logic [AW-1:0] r_k;
    logic [AW-1:0] r_best;
    logic [31:0]   r_best_time;
    logic [31:0]   r_start;
    logic [31:0]   r_wait;
    logic [31:0]   r_end;
    logic [31:0]   r_excess;

    logic          r_out_valid;
    logic [3:0]    r_out_index;
    logic [31:0]   r_out_start;
    logic [31:0]   r_out_wait;
    logic          r_out_over;
    logic [31:0]   r_out_total;

    logic          accept;
    logic          out_free;
    logic          finish;
    logic [8:0]    used;
    logic [8:0]    last_wide;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic [31:0]   rd_data;
    logic [31:0]   cmp_a, cmp_b;
    logic          cmp_lt;
    logic [32:0]   end_sum;
    logic [AW+3:0] best_wide;

    efsd_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    efsd_mem #(
        .DEPTH (MAX_SERVERS),
        .AW    (AW)
    ) u_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data),
        .i_wr_en   (finish),
        .i_wr_addr (r_best),
        .i_wr_data (r_end)
    );

    // handshake
    assign o_stall  = (r_state != efsd_pkg::S_IDLE);
    assign accept   = i_valid & (r_state == efsd_pkg::S_IDLE);
    assign out_free = ~r_out_valid | ~i_stall;
    assign finish   = (r_state == efsd_pkg::S_DONE) & out_free;

    // number of servers in use, clamped to 1..MAX_SERVERS
    always_comb begin
        used = {4'd0, cfg.active_servers};
        if (used == 9'd0) begin
            used = 9'd1;
        end
        if (used > MaxUsed) begin
            used = MaxUsed;
        end
        last_wide = used - 9'd1;
    end

    // memory read: entry 0 on accept, next entry during the scan
    always_comb begin
        rd_en   = 1'b0;
        rd_addr = r_k + AW'(1);
        if (accept) begin
            rd_en   = 1'b1;
            rd_addr = '0;
        end else if ((r_state == efsd_pkg::S_SCAN) && (r_k != r_last)) begin
            rd_en = 1'b1;
        end
    end

    // shared comparator: scan, start select, limit check
    always_comb begin
        cmp_a = rd_data;
        cmp_b = r_best_time;
        unique case (r_state)
            efsd_pkg::S_START: begin
                cmp_a = r_arrival;
                cmp_b = r_best_time;
            end
            efsd_pkg::S_DONE: begin
                cmp_a = {16'd0, cfg.wait_limit};
                cmp_b = r_wait;
            end
            default: ;
        endcase
    end
    assign cmp_lt = cmp_a < cmp_b;

    assign end_sum = {1'b0, r_start} + {17'd0, r_service};

    // sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            efsd_pkg::S_IDLE:  if (accept) n_state = efsd_pkg::S_SCAN;
            efsd_pkg::S_SCAN:  if (r_k == r_last) n_state = efsd_pkg::S_START;
            efsd_pkg::S_START: n_state = efsd_pkg::S_SUM;
            efsd_pkg::S_SUM:   n_state = efsd_pkg::S_DONE;
            efsd_pkg::S_DONE:  if (out_free) n_state = efsd_pkg::S_IDLE;
            default:           n_state = efsd_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= efsd_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_arrival <= i_arrival_time;
            r_service <= i_service_time;
            r_last    <= last_wide[AW-1:0];
            r_k       <= '0;
        end
        // scan keeps the earliest, lowest index on ties
        if (r_state == efsd_pkg::S_SCAN) begin
            if ((r_k == '0) || cmp_lt) begin
                r_best      <= r_k;
                r_best_time <= rd_data;
            end
            r_k <= r_k + AW'(1);
        end
        // start is the later of arrival and free time
        if (r_state == efsd_pkg::S_START) begin
            r_start <= cmp_lt ? r_best_time : r_arrival;
        end
        // wait and saturating end time
        if (r_state == efsd_pkg::S_SUM) begin
            r_wait <= r_start - r_arrival;
            r_end  <= end_sum[32] ? efsd_pkg::TimeMax : end_sum[31:0];
        end
    end

    assign best_wide = {4'd0, r_best};

    // over-limit count and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_excess    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && !i_stall) begin
                r_out_valid <= 1'b0;
            end
            if (finish) begin
                r_out_valid <= 1'b1;
                if (cmp_lt && (r_excess != efsd_pkg::TimeMax)) begin
                    r_excess <= r_excess + 32'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (finish) begin
            r_out_index <= best_wide[3:0];
            r_out_start <= r_start;
            r_out_wait  <= r_wait;
            r_out_over  <= cmp_lt;
            r_out_total <= (cmp_lt && (r_excess != efsd_pkg::TimeMax))
                           ? r_excess + 32'd1 : r_excess;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_server_index = r_out_index;
    assign o_start_time   = r_out_start;
    assign o_wait_time    = r_out_wait;
    assign o_over_limit   = r_out_over;
    assign o_over_total   = r_out_total;

endmodule

[sim/earliest_free_server_dispatch_tb.sv]
module earliest_free_server_dispatch_tb;

    localparam int NUM_SERVERS = 16;
    localparam int CYCLE_LIMIT = 600000;
    // longest scan plus pipeline, with margin, before touching the registers
    localparam int SETTLE_CYCLES = 24;
    localparam int PHASES = 15;
    localparam int JOBS_PER_PHASE = 130;
    localparam int DIR_ROWS = 30;

    // one dispatch decision as seen on the output channel
    typedef struct packed {
        logic [3:0]  server_index;
        logic [31:0] start_time;
        logic [31:0] wait_time;
        logic        over_limit;
        logic [31:0] over_total;
    } t_dispatch;

    typedef enum logic [1:0] {
        ROW_JOB,
        ROW_SET_ACTIVE,
        ROW_SET_LIMIT
    } t_row_kind;

    // directed row: a job (arrival, service) or a register write (value in arrival)
    typedef struct packed {
        t_row_kind   kind;
        logic [31:0] arrival;
        logic [15:0] service;
        logic        typed;
        t_dispatch   res;
    } t_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [31:0] i_arrival_time;
    logic [15:0] i_service_time;
    logic        o_valid;
    logic        i_stall;
    logic [3:0]  o_server_index;
    logic [31:0] o_start_time;
    logic [31:0] o_wait_time;
    logic        o_over_limit;
    logic [31:0] o_over_total;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    earliest_free_server_dispatch #(
        .MAX_SERVERS(NUM_SERVERS)
    ) DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_arrival_time (i_arrival_time),
        .i_service_time (i_service_time),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_server_index (o_server_index),
        .o_start_time   (o_start_time),
        .o_wait_time    (o_wait_time),
        .o_over_limit   (o_over_limit),
        .o_over_total   (o_over_total),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    // shadow of the dispatcher state
    logic [31:0] model_free_at [NUM_SERVERS];
    logic [31:0] model_excess;
    logic [4:0]  model_active;
    logic [15:0] model_limit;

    t_dispatch   dispatch_q[$];
    t_dispatch   exp_r;
    int          err_count;
    int          cycle_count;
    int          jobs_sent;
    int          reg_writes;
    int          over_seen;
    bit          tx_burst;
    bit          rx_burst;
    logic [31:0] now_t;

    // directed rows: extremes, saturation, server count corners, limit corners
    t_row dir_rows [DIR_ROWS] = '{
        '{ROW_JOB, 32'h0000_0000, 16'h0000, 1'b1,
          '{4'd0, 32'h0000_0000, 32'h0000_0000, 1'b0, 32'd0}},
        '{ROW_JOB, 32'h0000_0000, 16'd100, 1'b1,
          '{4'd0, 32'h0000_0000, 32'h0000_0000, 1'b0, 32'd0}},
        '{ROW_JOB, 32'd50, 16'd10, 1'b1,
          '{4'd0, 32'd100, 32'd50, 1'b1, 32'd1}},
        '{ROW_JOB, 32'd89, 16'd0, 1'b1,
          '{4'd0, 32'd110, 32'd21, 1'b1, 32'd2}},
        '{ROW_JOB, 32'd90, 16'd0, 1'b1,
          '{4'd0, 32'd110, 32'd20, 1'b0, 32'd2}},
        '{ROW_JOB, 32'hFFFF_FFFF, 16'hFFFF, 1'b1,
          '{4'd0, 32'hFFFF_FFFF, 32'h0000_0000, 1'b0, 32'd2}},
        '{ROW_JOB, 32'hFFFF_FFF0, 16'd5, 1'b1,
          '{4'd0, 32'hFFFF_FFFF, 32'd15, 1'b0, 32'd2}},
        '{ROW_JOB, 32'h0000_0000, 16'h0000, 1'b1,
          '{4'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 32'd3}},
        '{ROW_SET_ACTIVE, 32'd0, 16'h0000, 1'b0, '0},
        '{ROW_JOB, 32'h0000_0000, 16'd1, 1'b1,
          '{4'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 32'd4}},
        '{ROW_SET_ACTIVE, 32'd16, 16'h0000, 1'b0, '0},
        '{ROW_JOB, 32'h0000_0000, 16'h0000, 1'b1,
          '{4'd1, 32'h0000_0000, 32'h0000_0000, 1'b0, 32'd4}},
        '{ROW_JOB, 32'h0000_0000, 16'hFFFF, 1'b0, '0},
        '{ROW_JOB, 32'h0000_0000, 16'hFFFF, 1'b0, '0},
        '{ROW_JOB, 32'd1000, 16'd500, 1'b0, '0},
        '{ROW_SET_ACTIVE, 32'd31, 16'h0000, 1'b0, '0},
        '{ROW_SET_LIMIT, 32'd0, 16'h0000, 1'b0, '0},
        '{ROW_JOB, 32'd5, 16'd0, 1'b0, '0},
        '{ROW_JOB, 32'd5, 16'd0, 1'b0, '0},
        '{ROW_JOB, 32'hAAAA_AAAA, 16'h5555, 1'b0, '0},
        '{ROW_JOB, 32'h5555_5555, 16'hAAAA, 1'b0, '0},
        '{ROW_SET_LIMIT, 32'd65535, 16'h0000, 1'b0, '0},
        '{ROW_JOB, 32'h0000_0000, 16'h0000, 1'b0, '0},
        '{ROW_SET_ACTIVE, 32'd2, 16'h0000, 1'b0, '0},
        '{ROW_JOB, 32'h0000_0000, 16'd7, 1'b0, '0},
        '{ROW_JOB, 32'h0000_0000, 16'd7, 1'b0, '0},
        '{ROW_SET_ACTIVE, 32'd17, 16'h0000, 1'b0, '0},
        '{ROW_JOB, 32'h0000_0000, 16'h0000, 1'b0, '0},
        '{ROW_JOB, 32'd100, 16'd3, 1'b0, '0},
        '{ROW_SET_LIMIT, 32'd20, 16'h0000, 1'b0, '0}
    };

    // clock
    initial i_clk = 1'b0;
    always #2 i_clk = ~i_clk;

    // earliest free server pick and state update for one job
    function automatic t_dispatch predict_dispatch(input logic [31:0] arr,
                                                   input logic [15:0] svc);
        t_dispatch   r;
        int          n;
        int          best;
        int          k;
        logic [31:0] best_t;
        logic [32:0] sum;
        n = model_active;
        if (n < 1) n = 1;
        if (n > NUM_SERVERS) n = NUM_SERVERS;
        best = 0;
        best_t = model_free_at[0];
        for (k = 1; k < n; k++) begin
            if (model_free_at[k] < best_t) begin
                best_t = model_free_at[k];
                best = k;
            end
        end
        r.start_time = (best_t > arr) ? best_t : arr;
        r.wait_time = r.start_time - arr;
        sum = {1'b0, r.start_time} + {17'd0, svc};
        model_free_at[best] = sum[32] ? efsd_pkg::TimeMax : sum[31:0];
        r.over_limit = (r.wait_time > {16'd0, model_limit});
        if (r.over_limit && model_excess != efsd_pkg::TimeMax)
            model_excess = model_excess + 1;
        r.server_index = best[3:0];
        r.over_total = model_excess;
        return r;
    endfunction

    task automatic note_fail(input string msg);
        err_count++;
        if (err_count <= 10) $display("%s", msg);
    endtask

    // offer one job, wait for it to be taken, queue what it should produce
    task automatic send_job(input logic [31:0] arr, input logic [15:0] svc,
                            input logic typed, input t_dispatch typed_res);
        int        gap;
        t_dispatch r;
        gap = tx_burst ? 0 : $urandom_range(0, 15);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_arrival_time <= arr;
        i_service_time <= svc;
        do @(posedge i_clk); while (o_stall);
        r = predict_dispatch(arr, svc);
        if (typed) dispatch_q.push_back(typed_res);
        else dispatch_q.push_back(r);
        jobs_sent++;
        @(negedge i_clk);
    endtask

    // register write, only once every pending result has drained
    task automatic write_reg(input logic idx, input logic [31:0] value);
        logic [31:0] mask;
        mask = (idx == efsd_pkg::RegActive) ? 32'h0000_001F : 32'h0000_FFFF;
        i_valid <= 1'b0;
        while (dispatch_q.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= ($urandom & ~mask) | (value & mask);
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (idx == efsd_pkg::RegActive) model_active = value[4:0];
        else model_limit = value[15:0];
        reg_writes++;
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    // random job: mostly a rising arrival clock, some noise and wrap cases
    task automatic random_job();
        int          pick;
        logic [31:0] arr;
        logic [15:0] svc;
        pick = $urandom_range(0, 99);
        if (pick < 75) begin
            now_t = now_t + $urandom_range(0, 40);
            arr = now_t;
            svc = 16'($urandom_range(0, 200));
        end else if (pick < 85) begin
            arr = now_t;
            svc = 16'($urandom);
        end else if (pick < 95) begin
            arr = $urandom;
            svc = 16'($urandom);
        end else begin
            arr = 32'hFFFF_FFFF - $urandom_range(0, 300);
            svc = 16'($urandom);
        end
        send_job(arr, svc, 1'b0, '0);
    endtask

    // new server count and wait limit for a phase
    task automatic pick_settings(input bit both);
        int          which;
        int          pick;
        logic [31:0] v;
        which = both ? 0 : $urandom_range(0, 2);
        if (which != 2) begin
            pick = $urandom_range(0, 5);
            case (pick)
                0: v = 32'd0;
                1: v = 32'd1;
                2: v = 32'd16;
                3: v = $urandom_range(17, 31);
                default: v = $urandom_range(1, 16);
            endcase
            write_reg(efsd_pkg::RegActive, v);
        end
        if (which != 1) begin
            pick = $urandom_range(0, 3);
            case (pick)
                0: v = 32'd0;
                1: v = 32'd65535;
                2: v = $urandom_range(0, 100);
                default: v = $urandom_range(0, 65535);
            endcase
            write_reg(efsd_pkg::RegLimit, v);
        end
    endtask

    // stimulus
    initial begin
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_arrival_time = '0;
        i_service_time = '0;
        i_stall = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        err_count = 0;
        jobs_sent = 0;
        reg_writes = 0;
        over_seen = 0;
        tx_burst = 1'b0;
        rx_burst = 1'b0;
        now_t = '0;
        for (int k = 0; k < NUM_SERVERS; k++) model_free_at[k] = '0;
        model_excess = '0;
        model_active = efsd_pkg::ActiveReset;
        model_limit = efsd_pkg::LimitReset;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed table
        for (int r = 0; r < DIR_ROWS; r++) begin
            case (dir_rows[r].kind)
                ROW_JOB: begin
                    send_job(dir_rows[r].arrival, dir_rows[r].service,
                             dir_rows[r].typed, dir_rows[r].res);
                end
                ROW_SET_ACTIVE: begin
                    write_reg(efsd_pkg::RegActive, dir_rows[r].arrival);
                end
                default: begin
                    write_reg(efsd_pkg::RegLimit, dir_rows[r].arrival);
                end
            endcase
        end

        // random phases, each behind a fresh register setting
        for (int p = 0; p < PHASES; p++) begin
            pick_settings(p == 0);
            tx_burst = ($urandom_range(0, 3) == 0);
            rx_burst = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 4) == 0) now_t = $urandom;
            for (int j = 0; j < JOBS_PER_PHASE; j++) random_job();
        end
        i_valid <= 1'b0;

        // drain and let the pipeline settle
        while (dispatch_q.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES * 2) @(negedge i_clk);
        if (dispatch_q.size() != 0) note_fail("results still outstanding at end of run");
        $display("ran %0d jobs over %0d register writes, %0d results flagged over the limit",
                 jobs_sent, reg_writes, over_seen);
        $display("server counts 0 to 31, wait limits 0 to 65535, time saturation exercised");
        if (err_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    // receiver back-pressure
    initial begin
        int stall_len;
        wait (i_rst_n === 1'b1);
        @(negedge i_clk);
        forever begin
            stall_len = rx_burst ? 0 : $urandom_range(0, 15);
            if (stall_len > 0) begin
                i_stall <= 1'b1;
                repeat (stall_len) @(negedge i_clk);
                i_stall <= 1'b0;
            end
            do @(posedge i_clk); while (!o_valid);
            @(negedge i_clk);
        end
    end

    // compare each taken result against the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (dispatch_q.size() == 0) begin
                note_fail("result arrived with no job outstanding");
            end else begin
                exp_r = dispatch_q.pop_front();
                if (o_over_limit) over_seen++;
                if (o_server_index !== exp_r.server_index ||
                    o_start_time !== exp_r.start_time ||
                    o_wait_time !== exp_r.wait_time ||
                    o_over_limit !== exp_r.over_limit ||
                    o_over_total !== exp_r.over_total) begin
                    note_fail($sformatf({"dispatch mismatch: exp srv %0d start %h wait %h ",
                        "over %0d total %h / got srv %0d start %h wait %h over %0d total %h"},
                        exp_r.server_index, exp_r.start_time, exp_r.wait_time,
                        exp_r.over_limit, exp_r.over_total, o_server_index,
                        o_start_time, o_wait_time, o_over_limit, o_over_total));
                end
            end
        end
    end

    // run limit
    initial cycle_count = 0;
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

endmodule

[earliest_free_server_dispatch.f]
design/efsd_pkg.sv
design/efsd_cfg.sv
design/efsd_mem.sv
design/earliest_free_server_dispatch.sv
sim/earliest_free_server_dispatch_tb.sv
